>>> hdl/abb_pkg.sv
// shared types, constants and a helper function for the alpha bounding box block
// no dependencies
package abb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // register and result coordinate width
    localparam int COORD_W = 13;
    // counter width, enough for coordinates 0 .. MAX-1
    localparam int COUNT_W = 12;

    localparam int ALPHA_W   = 8;
    localparam int M_TDATA_W = 8 * COORD_W;
    localparam int M_TUSER_W = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [COORD_W-1:0] SIZE_RESET = COORD_W'(4096);

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } box_t;

    // per-pixel status from the scan side to the union side
    typedef struct packed {
        logic frame_end;
        logic found;
        box_t box;
    } frame_info_t;

    // a zero size acts as one, anything above the limit acts as the limit
    function automatic logic [COORD_W-1:0] eff_size(input logic [COORD_W-1:0] size,
                                                    input logic [COORD_W-1:0] limit);
        logic [COORD_W-1:0] res;
        if (size == '0) begin
            res = COORD_W'(1);
        end else if (size > limit) begin
            res = limit;
        end else begin
            res = size;
        end
        return res;
    endfunction

endpackage

>>> hdl/abb_scan.sv
// raster position counters and the bounding box of the frame under way
// depends on abb_pkg
module abb_scan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic [abb_pkg::ALPHA_W-1:0]     alpha,
    input  logic [abb_pkg::COORD_W-1:0]     frame_width,
    input  logic [abb_pkg::COORD_W-1:0]     frame_height,
    output logic                            frame_end,
    output abb_pkg::frame_info_t            info
);

    logic [abb_pkg::COUNT_W-1:0] col_reg, col_next;
    logic [abb_pkg::COUNT_W-1:0] row_reg, row_next;
    logic [abb_pkg::COUNT_W-1:0] min_x_reg, min_x_next;
    logic [abb_pkg::COUNT_W-1:0] max_x_reg, max_x_next;
    logic [abb_pkg::COUNT_W-1:0] min_y_reg, min_y_next;
    logic [abb_pkg::COUNT_W-1:0] max_y_reg, max_y_next;
    logic                        found_reg, found_next;

    logic [abb_pkg::COORD_W-1:0] w_eff;
    logic [abb_pkg::COORD_W-1:0] h_eff;
    logic [abb_pkg::COORD_W-1:0] col_inc;
    logic [abb_pkg::COORD_W-1:0] row_inc;
    logic                        row_end;
    logic                        opaque;

    assign w_eff   = abb_pkg::eff_size(frame_width, abb_pkg::COORD_W'(abb_pkg::MAX_WIDTH));
    assign h_eff   = abb_pkg::eff_size(frame_height, abb_pkg::COORD_W'(abb_pkg::MAX_HEIGHT));
    assign col_inc = {1'b0, col_reg} + abb_pkg::COORD_W'(1);
    assign row_inc = {1'b0, row_reg} + abb_pkg::COORD_W'(1);

    // counter may sit past the end after a size change, so compare with >=
    assign row_end   = (col_inc >= w_eff);
    assign frame_end = row_end && (row_inc >= h_eff);
    assign opaque    = (alpha != '0);

    // box including the current pixel
    always_comb begin
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        found_next = found_reg;
        if (opaque) begin
            found_next = 1'b1;
            if (!found_reg) begin
                min_x_next = col_reg;
                max_x_next = col_reg;
                min_y_next = row_reg;
                max_y_next = row_reg;
            end else begin
                if (col_reg < min_x_reg) min_x_next = col_reg;
                if (col_reg > max_x_reg) max_x_next = col_reg;
                if (row_reg < min_y_reg) min_y_next = row_reg;
                if (row_reg > max_y_reg) max_y_next = row_reg;
            end
        end
    end

    always_comb begin
        info.frame_end = frame_end;
        info.found     = found_next;
        info.box       = '0;
        if (found_next) begin
            info.box.left   = {1'b0, min_x_next};
            info.box.top    = {1'b0, min_y_next};
            info.box.right  = {1'b0, max_x_next} + abb_pkg::COORD_W'(1);
            info.box.bottom = {1'b0, max_y_next} + abb_pkg::COORD_W'(1);
        end
    end

    always_comb begin
        if (frame_end) begin
            col_next = '0;
            row_next = '0;
        end else if (row_end) begin
            col_next = '0;
            row_next = row_inc[abb_pkg::COUNT_W-1:0];
        end else begin
            col_next = col_inc[abb_pkg::COUNT_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
            found_reg <= 1'b0;
        end else if (step) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (frame_end) begin
                min_x_reg <= '0;
                max_x_reg <= '0;
                min_y_reg <= '0;
                max_y_reg <= '0;
                found_reg <= 1'b0;
            end else begin
                min_x_reg <= min_x_next;
                max_x_reg <= max_x_next;
                min_y_reg <= min_y_next;
                max_y_reg <= max_y_next;
                found_reg <= found_next;
            end
        end
    end

endmodule

>>> hdl/abb_union.sv
// running union box over a sequence and the result output register
// depends on abb_pkg
module abb_union (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  logic                              restart,
    input  abb_pkg::frame_info_t              info,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [abb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [abb_pkg::M_TUSER_W-1:0]     m_tuser
);

    abb_pkg::box_t                   union_reg, union_next, union_base;
    logic                            valid_reg, valid_next, valid_base;
    logic                            out_valid_reg;
    logic [abb_pkg::M_TDATA_W-1:0]   out_data_reg;
    logic [abb_pkg::M_TUSER_W-1:0]   out_user_reg;

    // restart clears the union before this pixel's frame is merged
    assign union_base = restart ? '0 : union_reg;
    assign valid_base = restart ? 1'b0 : valid_reg;

    always_comb begin
        union_next = union_base;
        valid_next = valid_base;
        if (info.frame_end && info.found) begin
            valid_next = 1'b1;
            if (!valid_base) begin
                union_next = info.box;
            end else begin
                if (info.box.left < union_base.left)     union_next.left   = info.box.left;
                if (info.box.top < union_base.top)       union_next.top    = info.box.top;
                if (info.box.right > union_base.right)   union_next.right  = info.box.right;
                if (info.box.bottom > union_base.bottom) union_next.bottom = info.box.bottom;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            union_reg     <= '0;
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end else begin
            if (step) begin
                union_reg <= union_next;
                valid_reg <= valid_next;
            end
            if (step && info.frame_end) begin
                out_valid_reg <= 1'b1;
                // union stays zero while it holds no frame
                out_data_reg  <= {union_next.bottom, union_next.right, union_next.top,
                                  union_next.left, info.box.bottom, info.box.right,
                                  info.box.top, info.box.left};
                out_user_reg  <= {!valid_next, !info.found};
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> hdl/alpha_bounding_box.sv
// alpha bounding box top level: one pixel per cycle unless a frame's last pixel meets a full output register
// latency: the result is on m_tdata the cycle after the last pixel's transfer
// throughput: one pixel per cycle; only a frame's last pixel waits on a full output register
// reset: aresetn synchronous active low, clears counters, boxes, union and sizes to 4096
// depends on abb_pkg, abb_scan, abb_union
module alpha_bounding_box (
    input  logic                              aclk,
    input  logic                              aresetn,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [abb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [abb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [abb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    // pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [abb_pkg::ALPHA_W-1:0]       s_tdata,   // alpha
    input  logic                              s_tuser,   // sequence_start
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // box_left, box_top, box_right, box_bottom, union_left, union_top, union_right,
    // union_bottom
    output logic [abb_pkg::M_TDATA_W-1:0]     m_tdata,
    // frame_empty, union_empty
    output logic [abb_pkg::M_TUSER_W-1:0]     m_tuser
);

    logic [abb_pkg::COORD_W-1:0] width_reg;
    logic [abb_pkg::COORD_W-1:0] height_reg;
    logic                        cfg_write;
    abb_pkg::cfg_reg_t           cfg_sel;
    logic                        step;
    logic                        frame_end;
    abb_pkg::frame_info_t        info;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = abb_pkg::cfg_reg_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= abb_pkg::SIZE_RESET;
            height_reg <= abb_pkg::SIZE_RESET;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                abb_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[abb_pkg::COORD_W-1:0];
                abb_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[abb_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            abb_pkg::REG_FRAME_WIDTH:
                prdata = abb_pkg::CFG_DATA_W'(width_reg);
            abb_pkg::REG_FRAME_HEIGHT:
                prdata = abb_pkg::CFG_DATA_W'(height_reg);
            default:
                prdata = '0;
        endcase
    end

    // only a frame's last pixel needs room in the output register
    assign s_tready = !m_tvalid || m_tready || !frame_end;
    assign step     = s_tvalid && s_tready;

    abb_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .alpha        (s_tdata),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .frame_end    (frame_end),
        .info         (info)
    );

    abb_union u_union (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .restart  (s_tuser),
        .info     (info),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // a new result only follows a frame's last pixel transfer
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(step && frame_end))
        else $error("result without frame end transfer");

    // a stalled result is never overwritten by the next frame end
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && frame_end) |-> !s_tready)
        else $error("frame end accepted while result stalled");

    // an empty frame reports an all zero box
    a_empty_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[4*abb_pkg::COORD_W-1:0] == '0))
        else $error("empty frame with nonzero box");

    // a non-empty frame has a proper box and leaves a non-empty union
    a_full_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |->
        (m_tdata[3*abb_pkg::COORD_W-1:2*abb_pkg::COORD_W] >
         m_tdata[abb_pkg::COORD_W-1:0]) && !m_tuser[1])
        else $error("non-empty frame with bad box or empty union");
`endif

endmodule

>>> dv/alpha_bounding_box_tb.sv
// testbench for alpha_bounding_box: streams frames of random alpha through the block,
// predicts each frame box and the union box, and checks every result transfer
// depends on abb_pkg and the alpha_bounding_box rtl
`timescale 1ns / 1ps

module alpha_bounding_box_tb;

    localparam int RESULT_W = abb_pkg::M_TDATA_W + abb_pkg::M_TUSER_W;
    localparam int CLK_HALF = 4;

    typedef enum int {
        FILL_EMPTY,
        FILL_SINGLE,
        FILL_SPARSE,
        FILL_DENSE,
        FILL_ENDS
    } fill_t;

    class box_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned col;
        int unsigned row;
        int unsigned min_x;
        int unsigned max_x;
        int unsigned min_y;
        int unsigned max_y;
        bit found;
        int unsigned union_box [4];
        bit union_valid;
        logic [RESULT_W-1:0] expected_boxes [$];
        int errors;
        int pixels;
        int frames;
        int empty_frames;
        int restarts;

        function new();
            width_reg = 4096;
            height_reg = 4096;
            col = 0;
            row = 0;
            min_x = 0;
            max_x = 0;
            min_y = 0;
            max_y = 0;
            found = 1'b0;
            union_box = '{default: 0};
            union_valid = 1'b0;
            errors = 0;
            pixels = 0;
            frames = 0;
            empty_frames = 0;
            restarts = 0;
        endfunction

        // zero acts as one, anything past the limit acts as the limit
        function int unsigned clamp_size(int unsigned size, int unsigned limit);
            if (size == 0) begin
                return 1;
            end
            return (size > limit) ? limit : size;
        endfunction

        function void set_size(abb_pkg::cfg_reg_t idx,
                               logic [abb_pkg::CFG_DATA_W-1:0] value);
            if (idx == abb_pkg::REG_FRAME_WIDTH) begin
                width_reg = int'(value[abb_pkg::COORD_W-1:0]);
            end else begin
                height_reg = int'(value[abb_pkg::COORD_W-1:0]);
            end
        endfunction

        function int pending();
            return expected_boxes.size();
        endfunction

        function void note_pixel(logic [abb_pkg::ALPHA_W-1:0] alpha, logic restart);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            bit row_end;
            bit frame_end;
            int unsigned box [4];
            logic [RESULT_W-1:0] want;
            w = clamp_size(width_reg, abb_pkg::MAX_WIDTH);
            h = clamp_size(height_reg, abb_pkg::MAX_HEIGHT);
            x = col;
            y = row;
            row_end = (x + 1 >= w);
            frame_end = row_end && (y + 1 >= h);
            pixels++;

            if (restart) begin
                union_box = '{default: 0};
                union_valid = 1'b0;
                restarts++;
            end

            if (alpha != '0) begin
                if (!found) begin
                    min_x = x;
                    max_x = x;
                    min_y = y;
                    max_y = y;
                    found = 1'b1;
                end else begin
                    if (x < min_x) min_x = x;
                    if (x > max_x) max_x = x;
                    if (y < min_y) min_y = y;
                    if (y > max_y) max_y = y;
                end
            end

            if (!frame_end) begin
                if (row_end) begin
                    col = 0;
                    row = y + 1;
                end else begin
                    col = x + 1;
                end
                return;
            end

            box = '{default: 0};
            if (found) begin
                box = '{min_x, min_y, max_x + 1, max_y + 1};
                if (!union_valid) begin
                    union_box = box;
                    union_valid = 1'b1;
                end else begin
                    if (box[0] < union_box[0]) union_box[0] = box[0];
                    if (box[1] < union_box[1]) union_box[1] = box[1];
                    if (box[2] > union_box[2]) union_box[2] = box[2];
                    if (box[3] > union_box[3]) union_box[3] = box[3];
                end
            end

            want = '0;
            for (int k = 0; k < 4; k++) begin
                want[k*abb_pkg::COORD_W +: abb_pkg::COORD_W] = abb_pkg::COORD_W'(box[k]);
                if (union_valid) begin
                    want[(4+k)*abb_pkg::COORD_W +: abb_pkg::COORD_W] =
                        abb_pkg::COORD_W'(union_box[k]);
                end
            end
            want[abb_pkg::M_TDATA_W] = !found;
            want[abb_pkg::M_TDATA_W+1] = !union_valid;
            expected_boxes.insert(expected_boxes.size(), want);
            frames++;
            if (!found) empty_frames++;

            col = 0;
            row = 0;
            min_x = 0;
            max_x = 0;
            min_y = 0;
            max_y = 0;
            found = 1'b0;
        endfunction

        function void check_result(logic [abb_pkg::M_TDATA_W-1:0] data,
                                   logic [abb_pkg::M_TUSER_W-1:0] user);
            string names [10] = '{"box_left", "box_top", "box_right", "box_bottom",
                                  "union_left", "union_top", "union_right", "union_bottom",
                                  "frame_empty", "union_empty"};
            logic [RESULT_W-1:0] want;
            logic [RESULT_W-1:0] got;
            int e;
            int a;
            got = {user, data};
            if (expected_boxes.size() == 0) begin
                $error("result transfer with nothing expected: box_left %0d, frame_empty %0d",
                       data[abb_pkg::COORD_W-1:0], user[0]);
                errors++;
                return;
            end
            want = expected_boxes.pop_front();
            for (int k = 0; k < 10; k++) begin
                if (k < 8) begin
                    e = int'(want[k*abb_pkg::COORD_W +: abb_pkg::COORD_W]);
                    a = int'(got[k*abb_pkg::COORD_W +: abb_pkg::COORD_W]);
                end else begin
                    e = int'(want[abb_pkg::M_TDATA_W + k - 8]);
                    a = int'(got[abb_pkg::M_TDATA_W + k - 8]);
                end
                if (e != a) begin
                    $error("%s: expected %0d, actual %0d", names[k], e, a);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [abb_pkg::CFG_ADDR_W-1:0] paddr;
    logic [abb_pkg::CFG_DATA_W-1:0] pwdata;
    logic [abb_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [abb_pkg::ALPHA_W-1:0]    s_tdata;   // alpha
    logic                           s_tuser;   // sequence_start
    logic                           m_tvalid;
    logic                           m_tready;
    // box_left, box_top, box_right, box_bottom, union_left, union_top, union_right,
    // union_bottom
    logic [abb_pkg::M_TDATA_W-1:0]  m_tdata;
    // frame_empty, union_empty
    logic [abb_pkg::M_TUSER_W-1:0]  m_tuser;

    box_scoreboard sb;
    bit src_idle = 1'b0;
    bit snk_idle = 1'b0;
    int hold_len = 0;

    alpha_bounding_box DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            // result first: it always belongs to an earlier pixel
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                sb.note_pixel(s_tdata, s_tuser);
            end
        end
    end

    // result side backpressure, including one long hold when asked
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end else if (snk_idle && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #16_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic write_size(input abb_pkg::cfg_reg_t idx,
                              input logic [abb_pkg::CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_size(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [abb_pkg::ALPHA_W-1:0] alpha, input logic restart);
        s_tvalid <= 1'b1;
        s_tdata  <= alpha;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // let the last transfer reach the scoreboard and outstanding frames come out,
    // then give the pipeline time to go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // whole frames of shaped content, plus an optional partial frame at the end
    task automatic run_frames(input int unsigned w, input int unsigned h,
                              input int unsigned nframes, input int unsigned extra);
        int unsigned fsize;
        int unsigned pos;
        int unsigned target;
        int unsigned pick;
        fill_t mode;
        logic [abb_pkg::ALPHA_W-1:0] alpha;
        logic [abb_pkg::ALPHA_W-1:0] level;
        logic restart;
        fsize = w * h;
        pos = 0;
        target = 0;
        mode = FILL_EMPTY;
        for (int unsigned n = 0; n < nframes * fsize + extra; n++) begin
            if (pos == 0) begin
                pick = $urandom_range(0, 19);
                if (pick < 3) mode = FILL_EMPTY;
                else if (pick < 8) mode = FILL_SINGLE;
                else if (pick < 13) mode = FILL_SPARSE;
                else if (pick < 16) mode = FILL_DENSE;
                else mode = FILL_ENDS;
                target = $urandom_range(0, fsize - 1);
            end
            level = abb_pkg::ALPHA_W'($urandom_range(1, 255));
            case (mode)
                FILL_EMPTY:  alpha = '0;
                FILL_SINGLE: alpha = (pos == target) ? level : '0;
                FILL_SPARSE: alpha = ($urandom_range(0, 31) == 0) ? level : '0;
                FILL_DENSE:  alpha = ($urandom_range(0, 3) == 0) ? '0 : level;
                default:     alpha = (pos == 0 || pos == fsize - 1) ? level : '0;
            endcase
            if (pos == 0) begin
                restart = ($urandom_range(0, 3) == 0);
            end else begin
                restart = ($urandom_range(0, 63) == 0);
            end
            send_pixel(alpha, restart);
            pos = (pos + 1 == fsize) ? 0 : pos + 1;
        end
    endtask

    initial begin
        // corner, transparent frame, restart mid-frame, restart on the last pixel
        logic [abb_pkg::ALPHA_W-1:0] dir_alpha [24] = '{8'd0, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0,
                                                        8'd0, 8'd0, 8'd0,   8'd0, 8'd0, 8'd0,
                                                        8'd0, 8'd0, 8'd0,   8'd0, 8'd128, 8'd0,
                                                        8'd0, 8'd0, 8'd0,   8'd0, 8'd0, 8'd7};
        logic dir_restart [24] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                   1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
        logic [abb_pkg::CFG_DATA_W-1:0] w_val;
        logic [abb_pkg::CFG_DATA_W-1:0] h_val;
        int unsigned w;
        int unsigned h;
        int unsigned nframes;
        int unsigned extra;
        int settings;
        int guard;

        sb = new();
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle = 1'b1;
        snk_idle = 1'b1;
        write_size(abb_pkg::REG_FRAME_WIDTH, 3);
        write_size(abb_pkg::REG_FRAME_HEIGHT, 2);
        settings = 1;
        for (int i = 0; i < 24; i++) begin
            send_pixel(dir_alpha[i], dir_restart[i]);
        end
        drain();

        for (int ph = 0; ph < 15; ph++) begin
            extra = 0;
            case (ph)
                0: begin
                    // zero sizes: every pixel is a frame, so results pile up during the hold
                    w_val = 0;
                    h_val = 0;
                    nframes = 60;
                end
                1: begin
                    // widest row, left unfinished so the next size lands mid-row
                    w_val = 4096;
                    h_val = 1;
                    nframes = 0;
                    extra = 40;
                end
                2: begin
                    // height past the limit, left unfinished as well
                    w_val = 1;
                    h_val = 8191;
                    nframes = 0;
                    extra = 40;
                end
                3: begin
                    // upper bits beyond the register are dropped
                    w_val = 32'hFFFF_E005;
                    h_val = 7;
                    nframes = 4;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        w_val = $urandom_range(9, 40);
                        h_val = $urandom_range(1, 4);
                    end else begin
                        w_val = $urandom_range(1, 8);
                        h_val = $urandom_range(1, 8);
                    end
                    nframes = 0;
                end
            endcase
            write_size(abb_pkg::REG_FRAME_WIDTH, w_val);
            write_size(abb_pkg::REG_FRAME_HEIGHT, h_val);
            settings++;
            w = sb.clamp_size(int'(w_val[abb_pkg::COORD_W-1:0]), abb_pkg::MAX_WIDTH);
            h = sb.clamp_size(int'(h_val[abb_pkg::COORD_W-1:0]), abb_pkg::MAX_HEIGHT);
            if (ph == 14) begin
                // closing stretch runs at full rate on both sides
                src_idle = 1'b0;
                snk_idle = 1'b0;
                nframes = 200 / (w * h);
                if (nframes == 0) nframes = 1;
            end else begin
                src_idle = ($urandom_range(0, 3) != 0);
                snk_idle = ($urandom_range(0, 3) != 0);
                if (nframes == 0 && extra == 0) begin
                    nframes = 130 / (w * h);
                    if (nframes == 0) nframes = 1;
                    // leave a frame unfinished so the next size lands mid-frame
                    if (w * h > 1 && $urandom_range(0, 2) == 0) begin
                        extra = $urandom_range(1, w * h - 1);
                    end
                end
            end
            if (ph == 0) hold_len = 300;
            run_frames(w, h, nframes, extra);
            drain();
        end

        guard = 0;
        while (sb.pending() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        if (sb.pending() != 0) begin
            $error("%0d frame results never arrived", sb.pending());
            sb.errors++;
        end
        repeat (10) @(posedge aclk);

        $display("run covered %0d pixel transfers and %0d frame results (%0d transparent)",
                 sb.pixels, sb.frames, sb.empty_frames);
        $display("over %0d frame size settings with %0d union restarts",
                 settings, sb.restarts);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> alpha_bounding_box.f
hdl/abb_pkg.sv
hdl/abb_scan.sv
hdl/abb_union.sv
hdl/alpha_bounding_box.sv
dv/alpha_bounding_box_tb.sv
